### sv/quad_attitude_pid_mixer_defines.svh
// Assertion helpers for the top module of the attitude controller.
`ifndef QUAD_ATTITUDE_PID_MIXER_DEFINES_SVH
`define QUAD_ATTITUDE_PID_MIXER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QAPM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define QAPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/qapm_pkg.sv
package qapm_pkg;

  localparam int LOOP_PERIOD_US_DEF = 2000;

  localparam logic [3:0] CFG_P_GAIN     = 4'd0;
  localparam logic [3:0] CFG_I_GAIN     = 4'd1;
  localparam logic [3:0] CFG_D_GAIN     = 4'd2;
  localparam logic [3:0] CFG_P_LIMIT    = 4'd3;
  localparam logic [3:0] CFG_I_LIMIT    = 4'd4;
  localparam logic [3:0] CFG_D_LIMIT    = 4'd5;
  localparam logic [3:0] CFG_INT_THRESH = 4'd6;
  localparam logic [3:0] CFG_CUT_THRESH = 4'd7;

  localparam int DIV_NW = 48;
  localparam int DIV_DW = 20;

  // The integration step divides by 10^6 = 64 * 15625. Every product is a multiple of 64, so the
  // step reduces to a rounded division by 15625, done as a multiply by a 2^43 reciprocal. The
  // reciprocal is exact for numerators below 2^29.
  localparam int INC_DIV   = 15625;
  localparam int INC_HALF  = 7812;
  localparam int INC_RECIP = 562949954;
  localparam int INC_SHIFT = 43;

  localparam logic [14:0] ANG_MAX  = 15'd25736;
  localparam logic signed [19:0] Z_NEG_START = 20'sd102944;

  typedef enum logic [1:0] {AC_IDLE, AC_SQRT, AC_CORDIC, AC_FIN} qapm_acos_st_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_ACOS_START, S_ACOS_WAIT, S_ERR_M, S_ERR, S_INC_M, S_INC_D,
    S_INC_W, S_SUM, S_IT, S_P, S_D, S_MIX, S_DONE
  } qapm_state_t;

  function automatic logic signed [15:0] sat_q(input logic signed [15:0] v);
    if (v > 16'sd16384) return 16'sd16384;
    if (v < -16'sd16384) return -16'sd16384;
    return v;
  endfunction

  function automatic logic [19:0] cordic_atan(input logic [3:0] i);
    case (i)
      4'd0: return 20'd51472;
      4'd1: return 20'd30386;
      4'd2: return 20'd16055;
      4'd3: return 20'd8150;
      4'd4: return 20'd4091;
      4'd5: return 20'd2047;
      4'd6: return 20'd1024;
      4'd7: return 20'd512;
      4'd8: return 20'd256;
      4'd9: return 20'd128;
      4'd10: return 20'd64;
      4'd11: return 20'd32;
      4'd12: return 20'd16;
      4'd13: return 20'd8;
      4'd14: return 20'd4;
      default: return 20'd2;
    endcase
  endfunction

endpackage

### sv/qapm_div.sv
module qapm_div import qapm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              busy,
  output logic [DIV_NW-1:0] quotient
);

  localparam int CW = $clog2(DIV_NW + 1);

  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [DIV_DW-1:0] rem_r, rem_nxt;
  logic [DIV_DW-1:0] dsr_r, dsr_nxt;
  logic [DIV_NW-1:0] quo_r, quo_nxt;
  logic [DIV_DW:0]   trial;

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    quo_nxt = quo_r;
    trial   = {rem_r, quo_r[DIV_NW-1]};
    if (start) begin
      cnt_nxt = CW'(DIV_NW);
      rem_nxt = '0;
      dsr_nxt = divisor;
      quo_nxt = dividend;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIV_DW'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIV_DW-1:0];
        quo_nxt = {quo_r[DIV_NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;

endmodule

### sv/qapm_acos.sv
module qapm_acos import qapm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] c,
  input  logic [28:0]        rem,
  output logic               busy,
  output logic [14:0]        ang
);

  qapm_acos_st_t st_r, st_nxt;
  logic [28:0]        n_r, n_nxt, r_r, r_nxt, bit_r, bit_nxt, trial;
  logic signed [15:0] c_r, c_nxt;
  logic signed [25:0] x_r, x_nxt, y_r, y_nxt, dx, dy, s_ext, c_ext;
  logic signed [19:0] z_r, z_nxt, zc;
  logic [3:0]         i_r, i_nxt;
  logic [14:0]        ang_r, ang_nxt;
  logic [16:0]        zr;

  always_comb begin
    st_nxt  = st_r;
    n_nxt   = n_r;
    r_nxt   = r_r;
    bit_nxt = bit_r;
    c_nxt   = c_r;
    x_nxt   = x_r;
    y_nxt   = y_r;
    z_nxt   = z_r;
    i_nxt   = i_r;
    ang_nxt = ang_r;
    trial   = r_r + bit_r;
    s_ext   = {11'b0, r_r[14:0]};
    c_ext   = 26'(c_r);
    dx      = y_r >>> i_r;
    dy      = x_r >>> i_r;
    zc      = (z_r < 0) ? '0 : z_r;
    zr      = 17'((zc + 20'sd4) >>> 3);
    case (st_r)
      AC_IDLE: begin
        if (start) begin
          n_nxt   = rem;
          r_nxt   = '0;
          bit_nxt = 29'd1 << 28;
          c_nxt   = c;
          st_nxt  = AC_SQRT;
        end
      end
      AC_SQRT: begin
        if (bit_r == '0) begin
          // Square root done: seed the vectoring pass.
          if (c_r < 0) begin
            x_nxt = s_ext <<< 8;
            y_nxt = (-c_ext) <<< 8;
            z_nxt = Z_NEG_START;
          end else begin
            x_nxt = c_ext <<< 8;
            y_nxt = s_ext <<< 8;
            z_nxt = '0;
          end
          i_nxt  = '0;
          st_nxt = AC_CORDIC;
        end else begin
          if (n_r >= trial) begin
            n_nxt = n_r - trial;
            r_nxt = (r_r >> 1) + bit_r;
          end else begin
            r_nxt = r_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
      end
      AC_CORDIC: begin
        if (y_r > 0) begin
          x_nxt = x_r + dx;
          y_nxt = y_r - dy;
          z_nxt = z_r + $signed(cordic_atan(i_r));
        end else begin
          x_nxt = x_r - dx;
          y_nxt = y_r + dy;
          z_nxt = z_r - $signed(cordic_atan(i_r));
        end
        i_nxt = i_r + 1'b1;
        if (i_r == 4'd15) st_nxt = AC_FIN;
      end
      AC_FIN: begin
        ang_nxt = (zr > {2'b0, ANG_MAX}) ? ANG_MAX : zr[14:0];
        st_nxt  = AC_IDLE;
      end
      default: st_nxt = AC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= AC_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    n_r   <= n_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
    c_r   <= c_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    i_r   <= i_nxt;
    ang_r <= ang_nxt;
  end

  assign busy = (st_r != AC_IDLE);
  assign ang  = ang_r;

endmodule

### sv/quad_attitude_pid_mixer.sv
// The sequence runs S_IDLE, S_SQ, S_ACOS_START, S_ACOS_WAIT, then ERR_M through D for each axis,
// the mixer step for each motor and S_DONE, which loads the output register; an item below the
// cutoff goes from S_IDLE straight to S_DONE. The 48-step integral-limit division takes most of
// the time (square root and CORDIC run beside it); it is skipped with i_gain zero. A new item is
// taken only in S_IDLE, once the last one is in the output register; low out_tready holds S_DONE.
// Reset (rst_n low, synchronous): state and config registers to reset values, integrals and out_tvalid clear.
module quad_attitude_pid_mixer import qapm_pkg::*; #(
  parameter int LOOP_PERIOD_US = LOOP_PERIOD_US_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // q_scalar, q_x, q_y, q_z, rate_x, rate_y, rate_z, base_thrust
  input  logic [127:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // motor_left_front, motor_right_front, motor_left_back, motor_right_back
  output logic [63:0]  out_tdata,
  // motors_cut
  output logic [0:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_index,
  input  logic [16:0]  cfg_data
);

`include "quad_attitude_pid_mixer_defines.svh"

  // Increment = e*INC_WHOLE + round((e*INC_FRAC) / INC_DIV) for an error magnitude e.
  localparam int INC_SCALE = LOOP_PERIOD_US * 32;
  localparam int INC_WHOLE = INC_SCALE / INC_DIV;
  localparam int INC_FRAC  = INC_SCALE % INC_DIV;

  logic [16:0] p_gain_r, d_gain_r;
  logic [13:0] i_gain_r;
  logic [14:0] p_limit_r, i_limit_r, d_limit_r;
  logic signed [15:0] int_th_r, cut_th_r;

  qapm_state_t st_r, st_nxt;
  logic signed [15:0] q_r [4];
  logic signed [15:0] rate_r [3];
  logic signed [15:0] base_r;
  logic integ_en_r;
  logic [1:0] axis_r, mix_r;
  logic [14:0] ang_r;
  logic [30:0] lim_r;
  logic signed [15:0] err_r;
  logic signed [31:0] sum_r;
  logic [23:0] inc_r;
  logic signed [39:0] tacc_r;
  logic signed [39:0] torque_r [3];
  logic signed [31:0] integ_r [3];
  logic [15:0] mot_r [4];
  logic cut_r;
  logic [63:0] out_data_r;
  logic out_cut_r, out_valid_r;

  logic signed [31:0] mul_a;
  logic signed [29:0] mul_b;
  logic signed [61:0] mul_p_r;

  logic acos_start, acos_busy;
  logic [14:0] acos_ang;
  logic div_start, div_busy;
  logic [DIV_NW-1:0] div_n, div_q;
  logic [DIV_DW-1:0] div_d;

  logic in_acc;
  logic signed [15:0] in_base;
  logic signed [30:0] pm, pmag;
  logic [16:0] err_mag;
  logic signed [15:0] err_abs;
  logic [28:0] inc_num;
  logic signed [33:0] sum_ext, lim_ext, inc_s;
  logic signed [61:0] plim, dlim, dcl, pcl;
  logic signed [41:0] mixv, motv, bq;

  assign cfg_ready = 1'b1;
  assign in_tready = (st_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_base   = $signed(in_tdata[127:112]);
  assign inc_num   = mul_p_r[28:0] + 29'(INC_HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r  <= 17'd16;
      i_gain_r  <= 14'd1;
      d_gain_r  <= 17'd9;
      p_limit_r <= 15'd100;
      i_limit_r <= 15'd0;
      d_limit_r <= 15'd100;
      int_th_r  <= '0;
      cut_th_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_P_GAIN:     p_gain_r  <= cfg_data;
        CFG_I_GAIN:     i_gain_r  <= cfg_data[13:0];
        CFG_D_GAIN:     d_gain_r  <= cfg_data;
        CFG_P_LIMIT:    p_limit_r <= cfg_data[14:0];
        CFG_I_LIMIT:    i_limit_r <= cfg_data[14:0];
        CFG_D_LIMIT:    d_limit_r <= cfg_data[14:0];
        CFG_INT_THRESH: int_th_r  <= $signed(cfg_data[15:0]);
        CFG_CUT_THRESH: cut_th_r  <= $signed(cfg_data[15:0]);
        default: ;
      endcase
    end
  end

  qapm_acos u_acos (
    .clk   (clk),
    .rst_n (rst_n),
    .start (acos_start),
    .c     (q_r[0]),
    .rem   (29'((62'sd268435456 - mul_p_r))),
    .busy  (acos_busy),
    .ang   (acos_ang)
  );

  qapm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Shared multiplier: operands picked by the sequencer, product registered.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      S_SQ: begin
        mul_a = 32'(q_r[0]);
        mul_b = 30'(q_r[0]);
      end
      S_ERR_M: begin
        mul_a = {17'b0, ang_r};
        mul_b = 30'(q_r[axis_r + 2'd1]);
      end
      S_INC_M: begin
        mul_a = 32'(err_abs);
        mul_b = 30'(INC_FRAC);
      end
      S_INC_D: begin
        mul_a = 32'(INC_RECIP);
        mul_b = {1'b0, inc_num};
      end
      S_SUM: begin
        mul_a = 32'(sum_ext);
        mul_b = {16'b0, i_gain_r};
      end
      S_IT: begin
        mul_a = 32'(err_r);
        mul_b = {13'b0, p_gain_r};
      end
      S_P: begin
        mul_a = 32'(rate_r[axis_r]);
        mul_b = {13'b0, d_gain_r};
      end
      default: ;
    endcase
  end

  always_comb begin
    pm      = mul_p_r[30:0];
    pmag    = (pm < 0) ? -pm : pm;
    err_mag = 17'((pmag + 31'sd8192) >>> 14);
    err_abs = (err_r < 0) ? -err_r : err_r;
    inc_s   = {10'b0, inc_r};
    if (err_r < 0) inc_s = -inc_s;
    sum_ext = 34'(integ_r[axis_r]) + (integ_en_r ? inc_s : 34'sd0);
    lim_ext = {3'b0, lim_r};
    if (i_gain_r == '0) sum_ext = '0;
    else if (sum_ext > lim_ext) sum_ext = lim_ext;
    else if (sum_ext < -lim_ext) sum_ext = -lim_ext;
    plim = {34'b0, p_limit_r, 13'b0};
    pcl  = (mul_p_r > plim) ? plim : ((mul_p_r < -plim) ? -plim : mul_p_r);
    dlim = {47'b0, d_limit_r};
    dcl  = (mul_p_r > dlim) ? dlim : ((mul_p_r < -dlim) ? -dlim : mul_p_r);
    bq   = 42'(base_r) <<< 13;
    case (mix_r)
      2'd0: mixv = 42'(torque_r[0]) + 42'(torque_r[1]) + 42'(torque_r[2]);
      2'd1: mixv = 42'(torque_r[0]) - 42'(torque_r[1]) - 42'(torque_r[2]);
      2'd2: mixv = -42'(torque_r[0]) + 42'(torque_r[1]) - 42'(torque_r[2]);
      default: mixv = -42'(torque_r[0]) - 42'(torque_r[1]) + 42'(torque_r[2]);
    endcase
    motv = bq - mixv;
  end

  always_comb begin
    st_nxt     = st_r;
    acos_start = 1'b0;
    div_start  = 1'b0;
    div_n      = {9'b0, i_limit_r, 24'b0};
    div_d      = {6'b0, i_gain_r};
    case (st_r)
      S_IDLE: begin
        if (in_acc) st_nxt = (in_base < cut_th_r) ? S_DONE : S_SQ;
      end
      S_SQ: st_nxt = S_ACOS_START;
      S_ACOS_START: begin
        acos_start = 1'b1;
        div_start  = (i_gain_r != '0);
        st_nxt     = S_ACOS_WAIT;
      end
      S_ACOS_WAIT: if (!acos_busy && !div_busy) st_nxt = S_ERR_M;
      S_ERR_M: st_nxt = S_ERR;
      S_ERR:   st_nxt = S_INC_M;
      S_INC_M: st_nxt = S_INC_D;
      S_INC_D: st_nxt = S_INC_W;
      S_INC_W: st_nxt = S_SUM;
      S_SUM: st_nxt = S_IT;
      S_IT:  st_nxt = S_P;
      S_P:   st_nxt = S_D;
      S_D:   st_nxt = (axis_r == 2'd2) ? S_MIX : S_ERR_M;
      S_MIX: if (mix_r == 2'd3) st_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 3; k++) integ_r[k] <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {mot_r[3], mot_r[2], mot_r[1], mot_r[0]};
        out_cut_r   <= cut_r;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (st_r == S_SUM) integ_r[axis_r] <= 32'(sum_ext);
    end
    case (st_r)
      S_IDLE: begin
        q_r[0]    <= sat_q($signed(in_tdata[15:0]));
        q_r[1]    <= sat_q($signed(in_tdata[31:16]));
        q_r[2]    <= sat_q($signed(in_tdata[47:32]));
        q_r[3]    <= sat_q($signed(in_tdata[63:48]));
        rate_r[0] <= $signed(in_tdata[79:64]);
        rate_r[1] <= $signed(in_tdata[95:80]);
        rate_r[2] <= $signed(in_tdata[111:96]);
        base_r    <= in_base;
        integ_en_r <= (in_base > int_th_r);
        cut_r     <= (in_base < cut_th_r);
        for (int k = 0; k < 4; k++) mot_r[k] <= '0;
        axis_r    <= '0;
        mix_r     <= '0;
      end
      S_ACOS_WAIT: begin
        ang_r <= acos_ang;
        lim_r <= (div_q > 48'h7FFF_FFFF) ? 31'h7FFF_FFFF : div_q[30:0];
      end
      S_ERR: err_r <= (pm < 0) ? 16'(err_mag) : -16'(err_mag);
      S_INC_W: inc_r <= 24'(mul_p_r >>> INC_SHIFT) + 24'(err_abs * INC_WHOLE);
      S_SUM: sum_r <= 32'(sum_ext);
      S_IT:  tacc_r <= 40'(mul_p_r >>> 11);
      S_P:   tacc_r <= tacc_r + 40'(pcl);
      S_D: begin
        torque_r[axis_r] <= tacc_r + (40'(dcl) <<< 13);
        axis_r <= axis_r + 2'd1;
      end
      S_MIX: begin
        if (motv < 0) mot_r[mix_r] <= '0;
        else if ((motv >>> 13) > 42'sd65535) mot_r[mix_r] <= 16'hFFFF;
        else mot_r[mix_r] <= motv[28:13];
        mix_r <= mix_r + 2'd1;
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_cut_r;

  `QAPM_ASSERT_NOW(a_cut_zero, out_tvalid && out_tuser[0], out_tdata == '0, "cut item with motors on")
  `QAPM_ASSERT_NEXT(a_busy_after_acc, in_acc, !in_tready, "item taken while busy")
  `QAPM_ASSERT_NOW(a_div_free, div_start, !div_busy, "divider restarted while busy")
  `QAPM_ASSERT_NEXT(a_int_zero, st_r == S_SUM && i_gain_r == '0, sum_r == '0, "integral not held")

endmodule
